FILE: hdl/hsd_pkg.sv
// hsd_pkg: widths, constants and position tables for the hamming sec decoder
// no dependencies; used by hamming_sec_decoder_core and hsd_checker
package hsd_pkg;

	localparam int CODE_W       = 64;
	localparam int DATA_W       = 57;
	localparam int LEN_W        = 7;
	localparam int CNT_W        = 6;
	localparam int SYN_W        = 6;
	localparam int POW_W        = 3;
	localparam int MAX_CODE_LEN = 64;

	localparam logic [LEN_W-1:0] LEN_RESET = 7'd7;

	// codeword bits whose 1-based position has bit i set
	function automatic logic [CODE_W-1:0] check_mask(input int i);
		logic [CODE_W-1:0] m;
		m = '0;
		for (int p = 1; p <= CODE_W; p++) begin
			m[p-1] = ((p >> i) & 1) != 0;
		end
		return m;
	endfunction

	// codeword bit index of the k-th position that is not a power of two
	function automatic int data_index(input int k);
		int cnt;
		int idx;
		cnt = 0;
		idx = 0;
		for (int p = 1; p <= CODE_W; p++) begin
			if ((p & (p - 1)) != 0) begin
				if (cnt == k) begin
					idx = p - 1;
				end
				cnt++;
			end
		end
		return idx;
	endfunction

endpackage

FILE: hdl/hamming_sec_decoder_core.sv
// hamming_sec_decoder_core: single error correcting hamming decoder, depends on hsd_pkg
// an accepted codeword is registered in stage 1, decoded, then registered in stage 2
// throughput: one codeword per cycle while out_stall is low
// reset: arst_n asynchronous active low, empties both stages, code_length returns to 7
// backpressure: input is taken while a finished result waits, as long as stage 1 is free
module hamming_sec_decoder_core (
	input  logic                        clk,
	input  logic                        arst_n,
	// configuration: codeword length in use
	input  logic                        cfg_write_en,
	input  logic [hsd_pkg::LEN_W-1:0]   cfg_write_data,
	// input channel
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [hsd_pkg::CODE_W-1:0]  codeword,
	// output channel
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [hsd_pkg::DATA_W-1:0]  data_bits,
	output logic [hsd_pkg::CNT_W-1:0]   data_count,
	output logic [hsd_pkg::SYN_W-1:0]   syndrome,
	output logic                        error_seen,
	output logic                        bit_corrected
);

	// configuration register
	logic [hsd_pkg::LEN_W-1:0]  code_length_q;

	// stage 1: captured codeword
	logic                       valid_s1;
	logic [hsd_pkg::CODE_W-1:0] codeword_s1;

	// stage 2: result register
	logic                       valid_s2;
	logic [hsd_pkg::DATA_W-1:0] data_bits_s2;
	logic [hsd_pkg::CNT_W-1:0]  data_count_s2;
	logic [hsd_pkg::SYN_W-1:0]  syndrome_s2;
	logic                       corrected_s2;

	// decode logic between the stages
	logic [hsd_pkg::LEN_W-1:0]  len_c;
	logic [hsd_pkg::CODE_W-1:0] len_mask_c;
	logic [hsd_pkg::CODE_W-1:0] cw_masked_c;
	logic [hsd_pkg::CODE_W-1:0] cw_fixed_c;
	logic [hsd_pkg::SYN_W-1:0]  syn_c;
	logic [hsd_pkg::SYN_W-1:0]  syn_m1_c;
	logic                       fix_c;
	logic [hsd_pkg::POW_W-1:0]  pow_cnt_c;
	logic [hsd_pkg::LEN_W-1:0]  cnt_c;
	logic [hsd_pkg::DATA_W-1:0] data_c;

	// handshake: each stage moves when its downstream slot is free
	logic s2_load;
	logic s1_load;

	assign s2_load  = !valid_s2 || !out_stall;
	assign s1_load  = !valid_s1 || s2_load;
	assign in_stall = !s1_load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			code_length_q <= hsd_pkg::LEN_RESET;
		end else if (cfg_write_en) begin
			code_length_q <= cfg_write_data;
		end
	end

	// stage 1 control and payload
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s1_load) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_load && in_valid) begin
			codeword_s1 <= codeword;
		end
	end

	always_comb begin
		// lengths past the maximum act as the maximum
		if (code_length_q > hsd_pkg::LEN_W'(hsd_pkg::MAX_CODE_LEN)) begin
			len_c = hsd_pkg::LEN_W'(hsd_pkg::MAX_CODE_LEN);
		end else begin
			len_c = code_length_q;
		end

		// drop bits at or above the length
		for (int k = 0; k < hsd_pkg::CODE_W; k++) begin
			len_mask_c[k] = hsd_pkg::LEN_W'(k) < len_c;
		end
		cw_masked_c = codeword_s1 & len_mask_c;

		// parity check i exists only while 2^i is below the length
		for (int i = 0; i < hsd_pkg::SYN_W; i++) begin
			syn_c[i] = (len_c > hsd_pkg::LEN_W'(1 << i))
				&& (^(cw_masked_c & hsd_pkg::check_mask(i)));
		end

		// flip the named bit when it lies inside the codeword
		fix_c    = (syn_c != '0) && ({1'b0, syn_c} <= len_c);
		syn_m1_c = syn_c - hsd_pkg::SYN_W'(1);
		if (fix_c) begin
			cw_fixed_c = cw_masked_c ^ (hsd_pkg::CODE_W'(1) << syn_m1_c);
		end else begin
			cw_fixed_c = cw_masked_c;
		end

		// data count is the length less the power-of-two positions it covers
		pow_cnt_c = '0;
		for (int i = 0; i <= hsd_pkg::SYN_W; i++) begin
			pow_cnt_c = pow_cnt_c
				+ hsd_pkg::POW_W'(len_c >= hsd_pkg::LEN_W'(1 << i));
		end
		cnt_c = len_c - {{(hsd_pkg::LEN_W - hsd_pkg::POW_W){1'b0}}, pow_cnt_c};
	end

	// compaction is fixed wiring: masked-off positions already read as zero
	for (genvar k = 0; k < hsd_pkg::DATA_W; k++) begin : g_pack
		localparam int SRC = hsd_pkg::data_index(k);
		assign data_c[k] = cw_fixed_c[SRC];
	end

	// stage 2 control and payload
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_load) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_load && valid_s1) begin
			data_bits_s2  <= data_c;
			data_count_s2 <= cnt_c[hsd_pkg::CNT_W-1:0];
			syndrome_s2   <= syn_c;
			corrected_s2  <= fix_c;
		end
	end

	assign out_valid     = valid_s2;
	assign data_bits     = data_bits_s2;
	assign data_count    = data_count_s2;
	assign syndrome      = syndrome_s2;
	assign error_seen    = syndrome_s2 != '0;
	assign bit_corrected = corrected_s2;

endmodule

FILE: hdl/hsd_checker.sv
// hsd_checker: port-level assertions for hamming_sec_decoder_core, bound below
// depends on hsd_pkg
module hsd_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        cfg_write_en,
	input logic [hsd_pkg::LEN_W-1:0]   cfg_write_data,
	input logic                        in_valid,
	input logic                        in_stall,
	input logic [hsd_pkg::CODE_W-1:0]  codeword,
	input logic                        out_valid,
	input logic                        out_stall,
	input logic [hsd_pkg::DATA_W-1:0]  data_bits,
	input logic [hsd_pkg::CNT_W-1:0]   data_count,
	input logic [hsd_pkg::SYN_W-1:0]   syndrome,
	input logic                        error_seen,
	input logic                        bit_corrected
);

	// error flag follows the syndrome
	a_err_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (error_seen == (syndrome != '0)))
		else $error("error_seen disagrees with syndrome");

	// a correction needs a nonzero syndrome
	a_fix_err: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && bit_corrected) |-> error_seen)
		else $error("bit_corrected without error");

	// never more data bits than a full length codeword carries
	a_cnt_max: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (data_count <= hsd_pkg::CNT_W'(hsd_pkg::DATA_W)))
		else $error("data_count out of range");

	// with the output draining, the input side is never held off
	a_no_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!out_stall |-> !in_stall)
		else $error("input stalled while output drains");

	// a held result keeps its data bits, syndrome and data count
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(data_bits)
			&& $stable(syndrome) && $stable(data_count)))
		else $error("stalled result changed");

endmodule

bind hamming_sec_decoder_core hsd_checker u_hsd_checker (.*);
